@@ hdl/bmps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bmps_pkg;

  localparam int unsigned MAX_ROWS   = 256;
  localparam int unsigned MAX_COLS   = 256;
  localparam int unsigned PIXEL_BITS = 16;

  // field widths fixed by the interface
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned FILL_W  = 16;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam int unsigned MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned EDIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned PER_W   = $clog2(2 * MAX_DIM + 1);
  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [31:0] PIX_MASK = 32'((64'd1 << PIXEL_BITS) - 64'd1);

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_BORDER_MODE = 2'd2,
    REG_FILL_VALUE  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    BM_CONSTANT   = 2'd0,
    BM_REPLICATE  = 2'd1,
    BM_REFLECT101 = 2'd2,
    BM_REFLECT    = 2'd3
  } border_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FOLD,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] row_coord;
    logic signed [COORD_W-1:0] col_coord;
    logic [PIX_W-1:0]          pixel_in;
  } in_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] sample_value;
    logic             used_fill;
  } out_rsp_t;

  function automatic logic [ADDR_W-1:0] pix_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

@@ hdl/border_mode_pixel_sampler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i  (func, row, col, pixel)
// out       output     out_valid_o / out_ready_i out_data_o (sample_value, used_fill)
// config    input      psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// a write request leaves the block idle; a sample inside the image or in replicate mode
// passes the read and response steps, a constant fill only the response step, and a
// mirrored sample the 16-step remainder loop, the fold, one pixel read and the response
// one request is worked on at a time; the next is taken while a result waits in the
// output register, a stalled result holds the block in its response step
// reset clears control and configuration; the pixel store is not cleared

module border_mode_pixel_sampler (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  bmps_pkg::in_req_t               in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output bmps_pkg::out_rsp_t              out_data_o,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [bmps_pkg::PADDR_W-1:0]    paddr,
  input  wire  [bmps_pkg::PDATA_W-1:0]    pwdata,
  output logic [bmps_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned CW = bmps_pkg::COORD_W;
  localparam int unsigned IW = bmps_pkg::IDX_W;
  localparam int unsigned EW = bmps_pkg::EDIM_W;
  localparam int unsigned PW = bmps_pkg::PER_W;

  // configuration
  logic [bmps_pkg::DIM_W-1:0]  image_rows_q, image_cols_q;
  bmps_pkg::border_mode_e      border_mode_q;
  logic [bmps_pkg::FILL_W-1:0] fill_value_q;
  logic                        cfg_we;
  bmps_pkg::reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = bmps_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q  <= '0;
      image_cols_q  <= '0;
      border_mode_q <= bmps_pkg::BM_CONSTANT;
      fill_value_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bmps_pkg::REG_IMAGE_ROWS:  image_rows_q  <= pwdata[bmps_pkg::DIM_W-1:0];
        bmps_pkg::REG_IMAGE_COLS:  image_cols_q  <= pwdata[bmps_pkg::DIM_W-1:0];
        bmps_pkg::REG_BORDER_MODE: border_mode_q <= bmps_pkg::border_mode_e'(pwdata[1:0]);
        bmps_pkg::REG_FILL_VALUE:  fill_value_q  <= pwdata[bmps_pkg::FILL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      bmps_pkg::REG_IMAGE_ROWS:  prdata = bmps_pkg::PDATA_W'(image_rows_q);
      bmps_pkg::REG_IMAGE_COLS:  prdata = bmps_pkg::PDATA_W'(image_cols_q);
      bmps_pkg::REG_BORDER_MODE: prdata = bmps_pkg::PDATA_W'(border_mode_q);
      bmps_pkg::REG_FILL_VALUE:  prdata = bmps_pkg::PDATA_W'(fill_value_q);
      default:                   prdata = '0;
    endcase
  end

  // effective dimensions and mirror periods
  logic [EW-1:0] rows_eff, cols_eff;
  logic [PW-1:0] per_r, per_c;
  logic          mirror_mode, zero_dim;

  assign rows_eff = (32'(image_rows_q) > bmps_pkg::MAX_ROWS) ? EW'(bmps_pkg::MAX_ROWS)
                                                               : EW'(image_rows_q);
  assign cols_eff = (32'(image_cols_q) > bmps_pkg::MAX_COLS) ? EW'(bmps_pkg::MAX_COLS)
                                                               : EW'(image_cols_q);
  assign per_r = (border_mode_q == bmps_pkg::BM_REFLECT101) ? PW'({rows_eff, 1'b0}) - PW'(2)
                                                             : PW'({rows_eff, 1'b0});
  assign per_c = (border_mode_q == bmps_pkg::BM_REFLECT101) ? PW'({cols_eff, 1'b0}) - PW'(2)
                                                             : PW'({cols_eff, 1'b0});
  assign mirror_mode = (border_mode_q == bmps_pkg::BM_REFLECT101) ||
                       (border_mode_q == bmps_pkg::BM_REFLECT);
  assign zero_dim = (rows_eff == '0) || (cols_eff == '0);

  // request decode
  logic [CW-1:0] r_u, c_u;
  logic          r_neg, c_neg, row_ok, col_ok, in_image;
  logic [IW-1:0] r_clamp, c_clamp;
  logic          in_fire, is_sample, fill_case, need_div;

  assign r_u      = in_data_i.row_coord;
  assign c_u      = in_data_i.col_coord;
  assign r_neg    = r_u[CW-1];
  assign c_neg    = c_u[CW-1];
  assign row_ok   = !r_neg && (32'(r_u) < 32'(rows_eff));
  assign col_ok   = !c_neg && (32'(c_u) < 32'(cols_eff));
  assign in_image = row_ok && col_ok;

  assign r_clamp = r_neg ? '0 : (row_ok ? IW'(r_u) : IW'(rows_eff - EW'(1)));
  assign c_clamp = c_neg ? '0 : (col_ok ? IW'(c_u) : IW'(cols_eff - EW'(1)));

  assign in_fire   = in_valid_i && in_ready_o;
  assign is_sample = (in_data_i.func == bmps_pkg::FUNC_SAMPLE);
  assign fill_case = !in_image && ((border_mode_q == bmps_pkg::BM_CONSTANT) || zero_dim);
  assign need_div  = !in_image && !fill_case && mirror_mode;

  // state machine
  bmps_pkg::state_e  state_q, state_d;
  logic [bmps_pkg::STEP_W-1:0] cnt_q;
  logic              div_last, out_free;
  logic              ld_start, div_step, fold_en, rd_en, ld_out;

  assign div_last = (cnt_q == bmps_pkg::STEP_W'(bmps_pkg::DIV_STEPS - 1));
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bmps_pkg::ST_IDLE: begin
        if (in_valid_i && is_sample) begin
          if (fill_case)     state_d = bmps_pkg::ST_RESP;
          else if (need_div) state_d = bmps_pkg::ST_DIV;
          else               state_d = bmps_pkg::ST_READ;
        end
      end
      bmps_pkg::ST_DIV:  if (div_last) state_d = bmps_pkg::ST_FOLD;
      bmps_pkg::ST_FOLD: state_d = bmps_pkg::ST_READ;
      bmps_pkg::ST_READ: state_d = bmps_pkg::ST_RESP;
      bmps_pkg::ST_RESP: if (out_free) state_d = bmps_pkg::ST_IDLE;
      default:           state_d = bmps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ld_start   = 1'b0;
    div_step   = 1'b0;
    fold_en    = 1'b0;
    rd_en      = 1'b0;
    ld_out     = 1'b0;
    case (state_q)
      bmps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ld_start   = in_valid_i && is_sample;
      end
      bmps_pkg::ST_DIV:  div_step = 1'b1;
      bmps_pkg::ST_FOLD: fold_en  = 1'b1;
      bmps_pkg::ST_READ: rd_en    = 1'b1;
      bmps_pkg::ST_RESP: ld_out   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmps_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ld_start)      cnt_q <= '0;
      else if (div_step) cnt_q <= cnt_q + bmps_pkg::STEP_W'(1);
    end
  end

  // remainder by the period, one quotient bit per cycle for both axes
  logic [CW-1:0] mag_r_q, mag_c_q;
  logic [PW-1:0] rem_r_q, rem_c_q, rem_r_d, rem_c_d;
  logic          neg_r_q, neg_c_q, fill_q;
  logic [IW-1:0] row_idx_q, col_idx_q, row_fold, col_fold;
  logic [PW:0]   sh_r, sh_c;

  assign sh_r    = {rem_r_q, mag_r_q[CW-1]};
  assign sh_c    = {rem_c_q, mag_c_q[CW-1]};
  assign rem_r_d = (sh_r >= {1'b0, per_r}) ? PW'(sh_r - {1'b0, per_r}) : sh_r[PW-1:0];
  assign rem_c_d = (sh_c >= {1'b0, per_c}) ? PW'(sh_c - {1'b0, per_c}) : sh_c[PW-1:0];

  function automatic logic [IW-1:0] fold_idx(logic neg, logic [PW-1:0] rem,
                                             logic [PW-1:0] per, logic [EW-1:0] size,
                                             bmps_pkg::border_mode_e mode);
    logic [PW-1:0] m;
    logic [PW-1:0] f;
    m = (neg && (rem != '0)) ? per - rem : rem;
    if (m >= PW'(size)) begin
      f = (mode == bmps_pkg::BM_REFLECT101) ? per - m : per - PW'(1) - m;
    end else begin
      f = m;
    end
    return (size <= EW'(1)) ? '0 : IW'(f);
  endfunction

  assign row_fold = fold_idx(neg_r_q, rem_r_q, per_r, rows_eff, border_mode_q);
  assign col_fold = fold_idx(neg_c_q, rem_c_q, per_c, cols_eff, border_mode_q);

  always_ff @(posedge clk_i) begin
    if (ld_start) begin
      mag_r_q   <= r_neg ? CW'(-r_u) : r_u;
      mag_c_q   <= c_neg ? CW'(-c_u) : c_u;
      neg_r_q   <= r_neg;
      neg_c_q   <= c_neg;
      rem_r_q   <= '0;
      rem_c_q   <= '0;
      fill_q    <= fill_case;
      row_idx_q <= r_clamp;
      col_idx_q <= c_clamp;
    end else if (div_step) begin
      mag_r_q <= mag_r_q << 1;
      mag_c_q <= mag_c_q << 1;
      rem_r_q <= rem_r_d;
      rem_c_q <= rem_c_d;
    end else if (fold_en) begin
      row_idx_q <= row_fold;
      col_idx_q <= col_fold;
    end
  end

  // pixel store
  logic [bmps_pkg::PIXEL_BITS-1:0] pix_mem [bmps_pkg::DEPTH];
  logic [bmps_pkg::PIXEL_BITS-1:0] rd_pix_q, wr_pix;
  logic                            wr_en;
  logic [bmps_pkg::ADDR_W-1:0]     wr_addr, rd_addr;

  assign wr_en   = in_fire && !is_sample && in_image;
  assign wr_addr = bmps_pkg::pix_addr(IW'(r_u), IW'(c_u));
  assign rd_addr = bmps_pkg::pix_addr(row_idx_q, col_idx_q);
  assign wr_pix  = bmps_pkg::PIXEL_BITS'(32'(in_data_i.pixel_in));

  always_ff @(posedge clk_i) begin
    if (wr_en) pix_mem[wr_addr] <= wr_pix;
    if (rd_en) rd_pix_q <= pix_mem[rd_addr];
  end

  // output register
  logic               out_valid_q;
  bmps_pkg::out_rsp_t out_q;
  logic [31:0]        rd_wide, fill_wide;

  assign rd_wide   = 32'(rd_pix_q);
  assign fill_wide = 32'(fill_value_q) & bmps_pkg::PIX_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_q.sample_value <= fill_q ? fill_wide[bmps_pkg::PIX_W-1:0]
                                   : rd_wide[bmps_pkg::PIX_W-1:0];
      out_q.used_fill    <= fill_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/bmps_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bmps_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input bmps_pkg::in_req_t  in_data_i,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input bmps_pkg::out_rsp_t out_data_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // a sample request keeps the block busy
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.func == bmps_pkg::FUNC_SAMPLE) |=> !in_ready_o)
    else $error("sample request did not occupy the block");

  // a write request finishes in its own cycle
  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.func == bmps_pkg::FUNC_WRITE) |=> in_ready_o)
    else $error("write request stalled the input");

  // nothing is in flight when a request is taken, so no result can show up next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without a sample in flight");

endmodule

bind border_mode_pixel_sampler bmps_checker u_bmps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
